### hw/rtl/dsgc_pkg.sv
// shared types and constants for the dds sine source with gated capture
`timescale 1ns / 1ps

package dsgc_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int READ_IDX_W  = 10;
    localparam int COUNT_W     = 11;
    localparam int SETTLE_W    = 16;
    localparam int PHASE_INC_W = 30;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 1'b1;

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_RESTART = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam longint      ONE_Q30     = 64'sd1073741824;
    localparam logic [63:0] DAC_SCALE   = 64'd4095;
    localparam longint      DAC_MAX     = 64'sd4095;

    localparam logic [63:0] SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                           64'd110, 64'd156, 64'd210};
    localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                           64'd90, 64'd132, 64'd182};

    typedef struct packed {
        logic [1:0]            req_type;
        logic [SAMPLE_W-1:0]   voltage_sample;
        logic [SAMPLE_W-1:0]   current_sample;
        logic [READ_IDX_W-1:0] read_index;
    } t_req_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] dac_value;
        logic [COUNT_W-1:0]  captured_count;
        logic                capture_full;
        logic [SAMPLE_W-1:0] read_voltage;
        logic [SAMPLE_W-1:0] read_current;
    } t_rsp_item;

endpackage

### hw/rtl/dsgc_req_if.sv
// request channel interface
`timescale 1ns / 1ps

interface dsgc_req_if;
    import dsgc_pkg::*;

    logic      valid;
    logic      ready;
    t_req_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/dsgc_rsp_if.sv
// result channel interface
`timescale 1ns / 1ps

interface dsgc_rsp_if;
    import dsgc_pkg::*;

    logic      valid;
    logic      ready;
    t_rsp_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/dds_sine_with_gated_capture.sv
// dds sine source with gated capture of voltage and current adc pairs
`timescale 1ns / 1ps

// One request per clock while i_req.ready is high: tick, restart or read. Each
// accepted request gives one result after a registered read of the sine rom and
// of the capture memory and then the output register; a stalled result does not
// stop the next request until both stages are full. The phase accumulator, cycle
// counter and capture index update in the accept cycle, so ticks run back to
// back. A write of phase_increment takes effect on the next request; the step is
// reduced modulo one table cycle with a mask, so TABLE_DEPTH must be a power of
// two. The capture memory is not cleared; reading an entry never written since
// reset returns arbitrary data.
module dds_sine_with_gated_capture #(
    parameter int TABLE_DEPTH   = 1024,
    parameter int CAPTURE_DEPTH = 1024,
    parameter int FRACTION_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dsgc_req_if.sink                        i_req,
    dsgc_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [dsgc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dsgc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dsgc_pkg::*;

    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int AW  = TAW + FRACTION_BITS;
    localparam int SW  = ((AW > PHASE_INC_W) ? AW : PHASE_INC_W) + 1;
    localparam int CW  = $clog2(CAPTURE_DEPTH + 1);
    localparam int CAW = $clog2(CAPTURE_DEPTH);
    localparam int RCW = (READ_IDX_W > CW) ? READ_IDX_W : CW;

    localparam logic [SW-1:0]  FULL_CYCLE = SW'(TABLE_DEPTH) << FRACTION_BITS;
    localparam logic [SW-1:0]  CYCLE_MASK = FULL_CYCLE - SW'(1);
    localparam logic [CW-1:0]  CAP_LIMIT  = CW'(CAPTURE_DEPTH);
    localparam logic [RCW-1:0] RD_LIMIT   = RCW'(CAPTURE_DEPTH);

    typedef logic [SAMPLE_W-1:0] t_rom [TABLE_DEPTH];

    function automatic longint taylor_q30(logic [63:0] x, logic want_sin);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] prod;
        longint      sum;
        x2   = (x * x) >> 30;
        term = want_sin ? x : 64'(ONE_Q30);
        sum  = longint'(term);
        for (int k = 0; k < 7; k++) begin
            prod = (term * x2) >> 30;
            if (want_sin) begin
                term = prod / SIN_DIV[k];
            end else begin
                term = prod / COS_DIV[k];
            end
            if ((k & 1) == 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return sum;
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] a;
        longint      s;
        longint      v;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            quad = 64'((4 * n) / TABLE_DEPTH);
            r    = 64'((4 * n) % TABLE_DEPTH);
            a    = (HALF_PI_Q30 * r) / TABLE_DEPTH;
            case (quad[1:0])
                2'd0:    s = taylor_q30(a, 1'b1);
                2'd1:    s = taylor_q30(a, 1'b0);
                2'd2:    s = -taylor_q30(a, 1'b1);
                default: s = -taylor_q30(a, 1'b0);
            endcase
            v = ONE_Q30 + s;
            if (v < 0) begin
                v = 0;
            end
            v = longint'((64'(v) * DAC_SCALE) >> 31);
            if (v > DAC_MAX) begin
                v = DAC_MAX;
            end
            rom[n] = SAMPLE_W'(v);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // configuration, step kept reduced modulo one table cycle
    logic [PHASE_INC_W-1:0] r_inc_red;
    logic                   r_inc_big;
    logic [SETTLE_W-1:0]    r_settle;
    logic [SW-1:0]          cfg_inc;

    // phase and capture state
    logic [AW-1:0]       r_acc;
    logic [SETTLE_W-1:0] r_cyc;
    logic [CW-1:0]       r_idx;
    logic [AW-1:0]       n_acc;
    logic [SETTLE_W-1:0] n_cyc;
    logic [CW-1:0]       n_idx;
    logic [SW-1:0]       sum;
    logic                wrap;
    logic [CW-1:0]       idx_eff;
    logic                cap_ok;
    logic                rd_ok;
    logic                is_tick;
    logic                is_restart;
    logic                is_read;
    logic                accept;
    logic                adv1;

    // memories and pipeline
    logic [2*SAMPLE_W-1:0] pair_mem [CAPTURE_DEPTH];
    logic [2*SAMPLE_W-1:0] r_pair_q;
    logic [SAMPLE_W-1:0]   r_rom_q;
    logic                  r1_valid;
    logic                  r1_rd_ok;
    logic [CW-1:0]         r1_count;
    logic                  r1_full;
    logic                  r_out_valid;
    t_rsp_item             r_out;

    assign accept      = i_req.valid && i_req.ready;
    assign adv1        = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r1_valid || adv1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign is_tick    = (i_req.data.req_type == REQ_TICK);
    assign is_restart = (i_req.data.req_type == REQ_RESTART);
    assign is_read    = (i_req.data.req_type == REQ_READ);

    assign cfg_inc = SW'(i_cfg_data[PHASE_INC_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_red <= '0;
            r_inc_big <= 1'b0;
            r_settle  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PHASE_INC: begin
                    r_inc_red <= PHASE_INC_W'(cfg_inc & CYCLE_MASK);
                    r_inc_big <= (cfg_inc >= FULL_CYCLE);
                end
                CFG_SETTLE: begin
                    r_settle <= i_cfg_data[SETTLE_W-1:0];
                end
                default: begin
                    r_settle <= r_settle;
                end
            endcase
        end
    end

    always_comb begin
        sum     = SW'(r_acc) + SW'(r_inc_red);
        wrap    = r_inc_big || (sum >= FULL_CYCLE);
        n_acc   = r_acc;
        n_cyc   = r_cyc;
        n_idx   = r_idx;
        idx_eff = r_idx;
        cap_ok  = 1'b0;
        if (is_tick) begin
            n_acc = (sum >= FULL_CYCLE) ? AW'(sum - FULL_CYCLE) : AW'(sum);
            if (wrap && (r_cyc != '1)) begin
                n_cyc = r_cyc + SETTLE_W'(1);
            end
            if (wrap && (n_cyc < r_settle)) begin
                idx_eff = '0;
            end
            cap_ok = (idx_eff < CAP_LIMIT);
            n_idx  = cap_ok ? idx_eff + CW'(1) : idx_eff;
        end else if (is_restart) begin
            n_acc = '0;
            n_cyc = '0;
            n_idx = '0;
        end
        rd_ok = is_read && (RCW'(i_req.data.read_index) < RD_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cyc <= '0;
            r_idx <= '0;
        end else if (accept) begin
            r_acc <= n_acc;
            r_cyc <= n_cyc;
            r_idx <= n_idx;
        end
    end

    // capture store and sine rom, one registered read each
    always_ff @(posedge i_clk) begin
        if (accept && cap_ok) begin
            pair_mem[idx_eff[CAW-1:0]] <= {i_req.data.voltage_sample,
                                           i_req.data.current_sample};
        end
        if (accept && rd_ok) begin
            r_pair_q <= pair_mem[CAW'(i_req.data.read_index)];
        end
        if (accept) begin
            r_rom_q  <= SINE_ROM[n_acc[FRACTION_BITS +: TAW]];
            r1_rd_ok <= rd_ok;
            r1_count <= n_idx;
            r1_full  <= (n_idx >= CAP_LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r1_valid <= 1'b1;
            end else if (adv1) begin
                r1_valid <= 1'b0;
            end
            if (r1_valid && adv1) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid && adv1) begin
            r_out.dac_value      <= r_rom_q;
            r_out.captured_count <= COUNT_W'(r1_count);
            r_out.capture_full   <= r1_full;
            r_out.read_voltage   <= r1_rd_ok ? r_pair_q[2*SAMPLE_W-1:SAMPLE_W] : '0;
            r_out.read_current   <= r1_rd_ok ? r_pair_q[SAMPLE_W-1:0] : '0;
        end
    end

endmodule

### tb/tb_dds_sine_with_gated_capture.sv
// self-checking testbench for the dds sine source with gated capture
`timescale 1ns / 1ps

module tb_dds_sine_with_gated_capture;
    import dsgc_pkg::*;

    localparam int TABLE_DEPTH   = 1024;
    localparam int CAPTURE_DEPTH = 1024;
    localparam int FRACTION_BITS = 20;

    localparam longint unsigned FULL_CYCLE = 64'(TABLE_DEPTH) << FRACTION_BITS;
    localparam logic [1:0]             REQ_UNUSED  = 2'd3;
    localparam logic [PHASE_INC_W-1:0] INC_MAX     = '1;
    localparam logic [SETTLE_W-1:0]    SETTLE_MAX  = '1;
    localparam int                     CYCLE_LIMIT = 400000;
    localparam int                     DRAIN_GAP   = 6;
    localparam int                     PLAN_ROWS   = 24;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] reg_val;
        t_req_item             req;
        bit                    pinned;
        t_rsp_item             want;
    } t_plan_row;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    dsgc_req_if req_bus ();
    dsgc_rsp_if rsp_bus ();

    dds_sine_with_gated_capture #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .CAPTURE_DEPTH (CAPTURE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    logic [SAMPLE_W-1:0]    sine_lut [TABLE_DEPTH];
    logic [SAMPLE_W-1:0]    volt_mem [CAPTURE_DEPTH];
    logic [SAMPLE_W-1:0]    curr_mem [CAPTURE_DEPTH];
    bit                     entry_written [CAPTURE_DEPTH];
    int                     written_idx [$];
    longint unsigned        phase_acc   = 0;
    int                     cycles_done = 0;
    int                     cap_idx     = 0;
    logic [PHASE_INC_W-1:0] step_reg    = '0;
    logic [SETTLE_W-1:0]    settle_reg  = '0;

    t_rsp_item due_outputs [$];
    t_plan_row plan [PLAN_ROWS];

    int mismatches    = 0;
    int requests_sent = 0;
    int reads_sent    = 0;
    int restarts_sent = 0;
    int outputs_seen  = 0;
    int cycle_count   = 0;
    int stall_left    = 0;
    bit calm          = 1'b0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint taylor_q30(input longint unsigned x, input bit want_sin);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint unsigned k;
        longint          sum;
        x2   = (x * x) >> 30;
        term = want_sin ? x : 64'd1073741824;
        sum  = longint'(term);
        for (k = 1; k <= 7; k++) begin
            d    = want_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
            term = ((term * x2) >> 30) / d;
            if (k[0]) begin
                sum -= longint'(term);
            end else begin
                sum += longint'(term);
            end
        end
        return sum;
    endfunction

    function automatic t_rsp_item advance_dds(input t_req_item it);
        t_rsp_item o;
        o = '0;
        case (it.req_type)
            REQ_TICK: begin
                phase_acc += step_reg;
                if (phase_acc >= FULL_CYCLE) begin
                    phase_acc -= FULL_CYCLE;
                    if (phase_acc >= FULL_CYCLE) begin
                        phase_acc %= FULL_CYCLE;
                    end
                    if (cycles_done < int'(SETTLE_MAX)) begin
                        cycles_done++;
                    end
                    if (cycles_done < int'(settle_reg)) begin
                        cap_idx = 0;
                    end
                end
                if (cap_idx < CAPTURE_DEPTH) begin
                    volt_mem[cap_idx] = it.voltage_sample;
                    curr_mem[cap_idx] = it.current_sample;
                    if (!entry_written[cap_idx]) begin
                        entry_written[cap_idx] = 1'b1;
                        written_idx = {written_idx, cap_idx};
                    end
                    cap_idx++;
                end
            end
            REQ_RESTART: begin
                phase_acc   = 0;
                cycles_done = 0;
                cap_idx     = 0;
            end
            REQ_READ: begin
                o.read_voltage = volt_mem[it.read_index];
                o.read_current = curr_mem[it.read_index];
            end
            default: begin
            end
        endcase
        o.dac_value      = sine_lut[(phase_acc >> FRACTION_BITS) % TABLE_DEPTH];
        o.captured_count = cap_idx[COUNT_W-1:0];
        o.capture_full   = (cap_idx >= CAPTURE_DEPTH);
        return o;
    endfunction

    function automatic t_plan_row ask(input logic [1:0] kind, input int volt, input int curr,
                                      input int idx);
        t_plan_row row;
        row.is_cfg  = 1'b0;
        row.reg_sel = '0;
        row.reg_val = '0;
        row.req     = '{kind, volt[SAMPLE_W-1:0], curr[SAMPLE_W-1:0], idx[READ_IDX_W-1:0]};
        row.pinned  = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    // capture buffer is never full in the rows that carry a typed result
    function automatic t_plan_row ask_pinned(input logic [1:0] kind, input int volt,
                                             input int curr, input int idx, input int dac,
                                             input int cnt, input int rv, input int rc);
        t_plan_row row;
        row        = ask(kind, volt, curr, idx);
        row.pinned = 1'b1;
        row.want   = '{dac[SAMPLE_W-1:0], cnt[COUNT_W-1:0], 1'b0,
                       rv[SAMPLE_W-1:0], rc[SAMPLE_W-1:0]};
        return row;
    endfunction

    function automatic t_plan_row set_reg(input logic [CFG_IDX_W-1:0] sel,
                                          input logic [CFG_DATA_W-1:0] val);
        t_plan_row row;
        row         = ask(REQ_TICK, 0, 0, 0);
        row.is_cfg  = 1'b1;
        row.reg_sel = sel;
        row.reg_val = val;
        return row;
    endfunction

    task automatic issue(input t_req_item it, input bit pinned, input t_rsp_item want);
        t_rsp_item due;
        req_bus.valid <= 1'b1;
        req_bus.data  <= it;
        do @(posedge clk); while (!req_bus.ready);
        due = advance_dds(it);
        due_outputs = {due_outputs, (pinned ? want : due)};
        requests_sent++;
        if (it.req_type == REQ_READ) begin
            reads_sent++;
        end
        if (it.req_type == REQ_RESTART) begin
            restarts_sent++;
        end
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 99) < 15) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
        req_bus.valid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= sel;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_PHASE_INC) begin
            step_reg = val[PHASE_INC_W-1:0];
        end else begin
            settle_reg = val[SETTLE_W-1:0];
        end
    endtask

    task automatic run_phase(input logic [PHASE_INC_W-1:0] inc, input logic [SETTLE_W-1:0] settle,
                             input int count, input int restart_pct, input int read_pct,
                             input bit fill);
        t_req_item it;
        int        sent;
        int        past_full;
        int        roll;
        sent      = 0;
        past_full = 0;
        write_reg(CFG_PHASE_INC, inc);
        write_reg(CFG_SETTLE, CFG_DATA_W'(settle));
        while (sent < count || (fill && past_full < 16)) begin
            roll              = $urandom_range(0, 99);
            it.voltage_sample = SAMPLE_W'($urandom_range(0, 4095));
            it.current_sample = SAMPLE_W'($urandom_range(0, 4095));
            it.read_index     = READ_IDX_W'($urandom_range(0, CAPTURE_DEPTH - 1));
            if (roll < restart_pct) begin
                it.req_type = REQ_RESTART;
            end else if (roll < restart_pct + 2) begin
                it.req_type = REQ_UNUSED;
            end else if (roll < restart_pct + 2 + read_pct && written_idx.size() != 0) begin
                it.req_type = REQ_READ;
                // only entries that were captured at some point may be read
                if (!entry_written[it.read_index]) begin
                    it.read_index = READ_IDX_W'(
                        written_idx[$urandom_range(0, written_idx.size() - 1)]);
                end
            end else begin
                it.req_type = REQ_TICK;
            end
            issue(it, 1'b0, '0);
            maybe_pause();
            sent++;
            if (cap_idx >= CAPTURE_DEPTH) begin
                past_full++;
            end
        end
    endtask

    task automatic compare_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic check_output(input t_rsp_item got);
        t_rsp_item want;
        outputs_seen++;
        if (due_outputs.size() == 0) begin
            $display("%0t: output with no request outstanding, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
        end
        want = due_outputs.pop_front();
        compare_field("dac_value", int'(want.dac_value), int'(got.dac_value));
        compare_field("captured_count", int'(want.captured_count), int'(got.captured_count));
        compare_field("capture_full", int'(want.capture_full), int'(got.capture_full));
        compare_field("read_voltage", int'(want.read_voltage), int'(got.read_voltage));
        compare_field("read_current", int'(want.read_current), int'(got.read_current));
    endtask

    always @(posedge clk) begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            check_output(rsp_bus.data);
        end
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 10) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= $urandom_range(0, 13);
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int              n;
        int              quad;
        longint unsigned r;
        longint unsigned ang;
        longint          s;
        longint          lvl;

        req_bus.valid <= 1'b0;
        req_bus.data  <= '0;

        for (n = 0; n < TABLE_DEPTH; n++) begin
            quad = (4 * n) / TABLE_DEPTH;
            r    = 64'((4 * n) % TABLE_DEPTH);
            ang  = (HALF_PI_Q30 * r) / TABLE_DEPTH;
            case (quad)
                0:       s = taylor_q30(ang, 1'b1);
                1:       s = taylor_q30(ang, 1'b0);
                2:       s = -taylor_q30(ang, 1'b1);
                default: s = -taylor_q30(ang, 1'b0);
            endcase
            lvl = 64'sd1073741824 + s;
            if (lvl < 0) begin
                lvl = 0;
            end
            lvl = (lvl * 64'sd4095) >>> 31;
            if (lvl > 4095) begin
                lvl = 4095;
            end
            sine_lut[n] = lvl[SAMPLE_W-1:0];
        end

        plan = '{
            ask_pinned(REQ_TICK, 0, 0, 0, 2047, 1, 0, 0),
            ask_pinned(REQ_TICK, 4095, 4095, 1023, 2047, 2, 0, 0),
            ask_pinned(REQ_TICK, 'hAAA, 'h555, 'h2AA, 2047, 3, 0, 0),
            ask_pinned(REQ_READ, 4095, 4095, 0, 2047, 3, 0, 0),
            ask_pinned(REQ_READ, 0, 0, 1, 2047, 3, 4095, 4095),
            ask_pinned(REQ_READ, 0, 0, 2, 2047, 3, 'hAAA, 'h555),
            ask_pinned(REQ_UNUSED, 4095, 4095, 1, 2047, 3, 0, 0),
            ask_pinned(REQ_RESTART, 0, 0, 0, 2047, 0, 0, 0),
            ask_pinned(REQ_READ, 0, 0, 1, 2047, 0, 4095, 4095),
            set_reg(CFG_PHASE_INC, 30'h2000_0000),
            set_reg(CFG_SETTLE, 30'd2),
            ask(REQ_TICK, 'h123, 'h456, 0),
            // second tick lands exactly on a full cycle
            ask(REQ_TICK, 'h800, 'h7FF, 0),
            ask(REQ_TICK, 'h001, 'hFFE, 0),
            ask(REQ_TICK, 'hFFF, 'h000, 0),
            set_reg(CFG_PHASE_INC, 30'h1000_0000),
            ask(REQ_TICK, 'h3C3, 'hC3C, 0),
            set_reg(CFG_PHASE_INC, INC_MAX),
            set_reg(CFG_SETTLE, CFG_DATA_W'(SETTLE_MAX)),
            ask(REQ_TICK, 'h0F0, 'hF0F, 0),
            ask(REQ_TICK, 'h555, 'hAAA, 0),
            ask(REQ_TICK, 'hFFF, 'hFFF, 0),
            ask(REQ_READ, 0, 0, 0),
            ask(REQ_RESTART, 0, 0, 0)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            end else begin
                issue(plan[i].req, plan[i].pinned, plan[i].want);
                maybe_pause();
            end
        end

        run_phase(INC_MAX, SETTLE_MAX, 25, 3, 15, 1'b0);
        run_phase('0, '0, 15, 5, 15, 1'b0);
        run_phase(PHASE_INC_W'($urandom_range(1 << 16, 1 << 26)),
                  SETTLE_W'($urandom_range(1, 6)), 40, 3, 15, 1'b0);
        // no restarts and no settling so the buffer fills up
        run_phase(PHASE_INC_W'($urandom_range(1 << 18, 1 << 23)), '0, 0, 0, 2, 1'b1);
        calm = 1'b1;
        run_phase(PHASE_INC_W'($urandom_range(1, INC_MAX)),
                  SETTLE_W'($urandom_range(1, 4)), 40, 4, 20, 1'b0);

        req_bus.valid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);

        $display("ran %0d requests (%0d reads, %0d restarts) through fill, wrap and settle cases",
                 requests_sent, reads_sent, restarts_sent);
        $display("%0d outputs compared, %0d field mismatches", outputs_seen, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
